// ===== rtl/decimal_number_parser_core_assert.svh =====
// Assertion macros shared by the decimal number parser RTL.
`ifndef DECIMAL_NUMBER_PARSER_CORE_ASSERT_SVH
`define DECIMAL_NUMBER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dnp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dnp assertion failed");

`endif

// ===== rtl/dnp_pkg.sv =====
// Package with widths, character codes and helpers of the decimal number parser.
`timescale 1ns / 1ps
package dnp_pkg;

	localparam int MANTISSA_BITS = 32;
	localparam int COUNT_BITS    = 8;
	localparam int CHAR_BITS     = 8;

	typedef logic [MANTISSA_BITS-1:0] mant_t;
	typedef logic [COUNT_BITS-1:0]    cnt_t;
	typedef logic [CHAR_BITS-1:0]     char_t;

	// ASCII codes the parser reacts to
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_POINT = 8'h2E;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	localparam mant_t MANT_MAX = '1;
	localparam cnt_t  CNT_MAX  = '1;

	// Saturating counter increment
	function automatic cnt_t cnt_inc(input cnt_t c);
		return (c == CNT_MAX) ? c : c + cnt_t'(1);
	endfunction

endpackage

// ===== rtl/dnp_ifs.sv =====
// Valid/ready stream interfaces for parser characters and parsed numbers.
`timescale 1ns / 1ps
interface dnp_char_if;
	import dnp_pkg::*;

	logic  valid;
	logic  ready;
	char_t ch;
	logic  start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface dnp_num_if;
	import dnp_pkg::*;

	logic  valid;
	logic  ready;
	logic  valid_res;
	logic  negative;
	mant_t mantissa;
	cnt_t  frac_digits;
	cnt_t  consumed;
	logic  overflow;

	modport source (output valid, output valid_res, output negative, output mantissa,
		output frac_digits, output consumed, output overflow, input ready);
	modport sink   (input valid, input valid_res, input negative, input mantissa,
		input frac_digits, input consumed, input overflow, output ready);
endinterface

// ===== rtl/decimal_number_parser_core.sv =====
// Decimal number parser: ASCII characters in, decimal fixed-point numbers out.
//
// Usage:
//   din  : one ASCII character per item; start_req marks the first character
//          of a number field. Characters outside a field are dropped.
//   dout : one item per finished number, raised by the first character that
//          cannot continue it (that character is consumed, not re-parsed).
//          value = (-1)^negative * mantissa * 10^-frac_digits.
// Path: a terminating character is captured in the input register, parsed
//   from there, and its result is presented on dout from the result register.
// Throughput: one character per cycle unless dout is held off, set by the
//   single-pass shift-add accumulate between the input and result registers.
// Stall: while a result waits on a held-off dout, the input register keeps
//   its character and the parser state does not move; din.ready drops once
//   the input register is full and rises again when the result is taken.
// Reset: arst_n clears the valid flags of the input and result registers and
//   all parser state; the block comes out idle, waiting for a character with
//   start_req set.
`timescale 1ns / 1ps
`include "decimal_number_parser_core_assert.svh"
module decimal_number_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	dnp_char_if.sink      din,
	dnp_num_if.source     dout
);
	import dnp_pkg::*;

	// input register
	logic  valid_s1;
	char_t ch_s1;
	logic  start_s1;

	// parser state
	logic  active_q, minus_q, point_q, digit_seen_q, sat_q;
	mant_t accum_q;
	cnt_t  frac_q, char_q;

	// result register
	logic  out_v_q;
	logic  res_ok_q, res_neg_q, res_ovf_q;
	mant_t res_mant_q;
	cnt_t  res_frac_q, res_cons_q;

	logic  adv, take_s1, live, lead_minus, is_digit, is_point, emit, ovf;
	logic  b_minus, b_point, b_digit, b_sat;
	mant_t b_accum;
	cnt_t  b_frac, b_char;
	logic [3:0]               digit_val;
	logic [MANTISSA_BITS+3:0] prod;

	// handshake: result register frees on take, input register drains on advance
	assign adv       = !out_v_q || dout.ready;
	assign din.ready = !valid_s1 || adv;
	assign take_s1   = valid_s1 && adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			ch_s1    <= din.ch;
			start_s1 <= din.start_req;
		end
	end

	// base state: a start clears the number in progress
	always_comb begin
		b_minus = start_s1 ? 1'b0 : minus_q;
		b_point = start_s1 ? 1'b0 : point_q;
		b_digit = start_s1 ? 1'b0 : digit_seen_q;
		b_sat   = start_s1 ? 1'b0 : sat_q;
		b_accum = start_s1 ? '0 : accum_q;
		b_frac  = start_s1 ? '0 : frac_q;
		b_char  = start_s1 ? '0 : char_q;
	end

	// character classes and accumulate step
	assign live       = start_s1 || active_q;
	assign lead_minus = start_s1 && (ch_s1 == CH_MINUS);
	assign is_digit   = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign is_point   = (ch_s1 == CH_POINT) && !b_point;
	assign digit_val  = 4'(ch_s1 - CH_ZERO);
	assign prod       = ({4'b0, b_accum} << 3) + ({4'b0, b_accum} << 1)
		+ (MANTISSA_BITS+4)'(digit_val);
	assign ovf        = b_sat || (prod[MANTISSA_BITS+3:MANTISSA_BITS] != 4'b0);
	assign emit       = take_s1 && live && !lead_minus && !is_digit && !is_point;

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			minus_q      <= 1'b0;
			point_q      <= 1'b0;
			digit_seen_q <= 1'b0;
			sat_q        <= 1'b0;
			accum_q      <= '0;
			frac_q       <= '0;
			char_q       <= '0;
		end else if (take_s1 && live) begin
			if (lead_minus) begin
				active_q     <= 1'b1;
				minus_q      <= 1'b1;
				point_q      <= 1'b0;
				digit_seen_q <= 1'b0;
				sat_q        <= 1'b0;
				accum_q      <= '0;
				frac_q       <= '0;
				char_q       <= cnt_inc('0);
			end else if (is_digit) begin
				active_q     <= 1'b1;
				minus_q      <= b_minus;
				point_q      <= b_point;
				digit_seen_q <= 1'b1;
				sat_q        <= ovf;
				accum_q      <= ovf ? MANT_MAX : prod[MANTISSA_BITS-1:0];
				frac_q       <= b_point ? cnt_inc(b_frac) : b_frac;
				char_q       <= cnt_inc(b_char);
			end else if (is_point) begin
				active_q     <= 1'b1;
				minus_q      <= b_minus;
				point_q      <= 1'b1;
				digit_seen_q <= b_digit;
				sat_q        <= b_sat;
				accum_q      <= b_accum;
				frac_q       <= b_frac;
				char_q       <= cnt_inc(b_char);
			end else begin
				// terminator: number is reported, parser goes idle
				active_q     <= 1'b0;
				minus_q      <= 1'b0;
				point_q      <= 1'b0;
				digit_seen_q <= 1'b0;
				sat_q        <= 1'b0;
				accum_q      <= '0;
				frac_q       <= '0;
				char_q       <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_ok_q   <= b_digit;
			res_neg_q  <= b_minus;
			res_mant_q <= b_digit ? b_accum : '0;
			res_frac_q <= b_digit ? b_frac : '0;
			res_cons_q <= b_char;
			res_ovf_q  <= b_digit && b_sat;
		end
	end

	assign dout.valid       = out_v_q;
	assign dout.valid_res   = res_ok_q;
	assign dout.negative    = res_neg_q;
	assign dout.mantissa    = res_mant_q;
	assign dout.frac_digits = res_frac_q;
	assign dout.consumed    = res_cons_q;
	assign dout.overflow    = res_ovf_q;

	// checks
	`DNP_ASSERT_NOW(a_sat_holds_max, clk, arst_n, sat_q, accum_q == MANT_MAX)
	`DNP_ASSERT_NOW(a_frac_needs_digit, clk, arst_n, frac_q != '0, digit_seen_q && point_q)
	`DNP_ASSERT_NOW(a_empty_result, clk, arst_n, out_v_q && !res_ok_q,
		res_mant_q == '0 && res_frac_q == '0 && !res_ovf_q)
	`DNP_ASSERT_NEXT(a_idle_after_emit, clk, arst_n, emit, !active_q && char_q == '0)

endmodule
